### sv/hfc_pkg.sv
// package: types and constants for the half/single float converter
package hfc_pkg;

    typedef enum logic
    {
        CMD_NARROW = 1'b0,
        CMD_WIDEN  = 1'b1
    } cmd_t;

    localparam logic [15:0] HALF_SIGN   = 16'h8000;
    localparam logic [15:0] HALF_INF    = 16'h7c00;
    localparam logic [9:0]  MANT_MASK   = 10'h3ff;
    localparam logic [4:0]  HALF_EXP_MAX = 5'h1f;
    localparam logic [7:0]  SINGLE_EXP_MAX = 8'hff;
    localparam logic [7:0]  SINGLE_BIAS = 8'd127;
    localparam logic [7:0]  HALF_BIAS   = 8'd15;
    localparam logic [7:0]  SUB_EXP_START = 8'd113;

    // request payloads
    typedef struct packed
    {
        cmd_t        cmd;
        logic [31:0] operand_bits;
    } in_req_t;

    typedef struct packed
    {
        logic [31:0] result_bits;
    } out_req_t;

endpackage

### sv/hfc_in_if.sv
// interface: input request channel
interface hfc_in_if;
    logic                 valid;
    logic                 ready;
    hfc_pkg::cmd_t        cmd;
    logic [31:0]          operand_bits;

    modport source (output valid, output cmd, output operand_bits, input ready);
    modport sink   (input valid, input cmd, input operand_bits, output ready);
endinterface

### sv/hfc_out_if.sv
// interface: result request channel
interface hfc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_bits;

    modport source (output valid, output result_bits, input ready);
    modport sink   (input valid, input result_bits, output ready);
endinterface

### sv/half_float_convert.sv
// top level: binary32 / binary16 converter, one request per cycle when out_ch is not stalled
//
//  channel   dir   fields
//  in_ch     in    cmd, operand_bits
//  out_ch    out   result_bits
//
// one request per cycle sustained while out_ch is ready; input register, then
// result register. the conversion is a single pass of logic with a ten-bit
// leading-zero count. rst_n clears both valid flags only. a stalled result
// holds; the input stage takes one more request behind it, then holds too.
module half_float_convert
(
    input  logic  clk,
    input  logic  rst_n,
    hfc_in_if.sink    in_ch,
    hfc_out_if.source out_ch
);
    import hfc_pkg::*;

    logic        in_valid_reg;
    in_req_t     in_data_reg;
    logic        out_valid_reg;
    out_req_t    out_data_reg;
    logic        out_load;
    logic        in_load;
    logic [31:0] conv;

    assign out_load = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_load  = !in_valid_reg || out_load;
    assign in_ch.ready = in_load;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_load)
            in_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_load && in_ch.valid)
        begin
            in_data_reg.cmd          <= in_ch.cmd;
            in_data_reg.operand_bits <= in_ch.operand_bits;
        end
    end

    // conversion logic
    always_comb
    begin
        logic [15:0] sgn_h;
        logic [8:0]  rexp;
        logic [4:0]  hexp;
        logic [9:0]  hman;
        logic [3:0]  lz;
        logic [10:0] shifted;
        logic [7:0]  sexp;
        logic [15:0] h;
        conv    = '0;
        sgn_h   = in_data_reg.operand_bits[31:16] & HALF_SIGN;
        // rebias in nine bits: e - 112 ranges -112..143
        rexp    = {1'b0, in_data_reg.operand_bits[30:23]}
                  - {1'b0, SINGLE_BIAS} + {1'b0, HALF_BIAS};
        h       = in_data_reg.operand_bits[15:0];
        hexp    = h[14:10];
        hman    = h[9:0] & MANT_MASK;
        lz      = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (hman[i])
                lz = 4'(9 - i);
        end
        shifted = {hman, 1'b0} << lz;
        sexp    = '0;
        unique case (in_data_reg.cmd)
            CMD_NARROW:
            begin
                if (in_data_reg.operand_bits[30:23] <= 8'd112)
                    conv = {16'd0, sgn_h};
                else if (in_data_reg.operand_bits[30:23] >= 8'd143)
                    conv = {16'd0, sgn_h | HALF_INF};
                else
                    conv = {16'd0, sgn_h | {1'b0, rexp[4:0], 10'd0}
                            | {6'd0, in_data_reg.operand_bits[22:13]}};
            end
            CMD_WIDEN:
            begin
                if (hexp == 5'd0)
                begin
                    if (hman == 10'd0)
                        conv = {h[15], 31'd0};
                    else
                    begin
                        // subnormal: shift so bit 10 is set, then drop it
                        sexp = SUB_EXP_START - 8'(lz) - 8'd1;
                        conv = {h[15], sexp, shifted[9:0], 13'd0};
                    end
                end
                else if (hexp == HALF_EXP_MAX)
                    conv = {h[15], SINGLE_EXP_MAX, hman, 13'd0};
                else
                begin
                    sexp = {3'd0, hexp} + SINGLE_BIAS - HALF_BIAS;
                    conv = {h[15], sexp, hman, 13'd0};
                end
            end
            default: conv = '0;
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg.result_bits <= conv;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.result_bits = out_data_reg.result_bits;

endmodule
